/* hw/rtl/ntbp_pkg.sv */
// ----------------------------------------------------------------------------
// ntbp_pkg
// Shared types, constants and the symbol decoder for the two-bit packer.
// ----------------------------------------------------------------------------
package ntbp_pkg;

    // ascii letters of the four definite bases
    localparam logic [7:0] CHAR_A_UC = 8'h41;
    localparam logic [7:0] CHAR_A_LC = 8'h61;
    localparam logic [7:0] CHAR_C_UC = 8'h43;
    localparam logic [7:0] CHAR_C_LC = 8'h63;
    localparam logic [7:0] CHAR_G_UC = 8'h47;
    localparam logic [7:0] CHAR_G_LC = 8'h67;
    localparam logic [7:0] CHAR_T_UC = 8'h54;
    localparam logic [7:0] CHAR_T_LC = 8'h74;

    // two-bit base codes
    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    // hash value at the start of every sequence
    localparam logic [63:0] HASH_SEED = 64'd1;

    // result kinds
    typedef enum logic [1:0] {
        KIND_BASE    = 2'd0,
        KIND_FLAG    = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    // decoded symbol
    typedef struct packed {
        logic [1:0] code;
        logic       amb;
    } sym_code_t;

    // all results caused by one item, stored as one queue entry
    typedef struct packed {
        logic        has_base;
        logic        has_flag;
        logic        has_summary;
        logic [7:0]  base_byte;
        logic [7:0]  flag_byte;
        logic [63:0] hash;
        logic        definite;
    } rec_t;

    // map an ascii character to its code and ambiguity bit
    function automatic sym_code_t classify(input logic [7:0] sym);
        sym_code_t res;
        res.code = CODE_A;
        res.amb  = 1'b0;
        if (sym == CHAR_A_UC || sym == CHAR_A_LC)
        begin
            res.code = CODE_A;
        end
        else if (sym == CHAR_C_UC || sym == CHAR_C_LC)
        begin
            res.code = CODE_C;
        end
        else if (sym == CHAR_G_UC || sym == CHAR_G_LC)
        begin
            res.code = CODE_G;
        end
        else if (sym == CHAR_T_UC || sym == CHAR_T_LC)
        begin
            res.code = CODE_T;
        end
        else
        begin
            res.amb = 1'b1;
        end
        return res;
    endfunction

endpackage

/* hw/rtl/nucleotide_two_bit_packer_core.sv */
// ----------------------------------------------------------------------------
// nucleotide_two_bit_packer_core
// Packs ascii nucleotides into two-bit base bytes and ambiguity flag bytes,
// with a per-sequence hash summary.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one character per item in symbol,
//   with last_base high on the final character of a sequence.
//   Output channel (out_valid / out_stall): results with kind base byte,
//   flag byte or summary; end_of_run marks the last result of an item.
//   Results: an item's results enter the result queue when the item is
//   accepted and are offered once the earlier entries have gone out.
//   Throughput: one item per cycle while out_stall is low and each item
//   causes at most one result. An item that causes n results occupies the
//   output for n handshakes (n is 2 at every eighth base and 3 at the last base); a
//   two-entry result queue absorbs that and raises in_stall when full.
//   Stall: while out_stall is high the offered result holds; input items
//   keep being accepted until the queue holds two pending items.
//   Reset: state clears, hash restarts at one, no result is pending.
// ----------------------------------------------------------------------------
module nucleotide_two_bit_packer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  symbol,
    input  logic        last_base,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  packed_byte,
    output logic [63:0] seq_hash,
    output logic        all_definite,
    output logic        end_of_run
);

    logic              accept;
    logic              push;
    logic              full;
    ntbp_pkg::rec_t    rec;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    // per-item decode and state update
    ntbp_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .symbol    (symbol),
        .last_base (last_base),
        .push      (push),
        .rec       (rec)
    );

    // result queue and serializer
    ntbp_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .rec          (rec),
        .full         (full),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .packed_byte  (packed_byte),
        .seq_hash     (seq_hash),
        .all_definite (all_definite),
        .end_of_run   (end_of_run)
    );

endmodule

/* hw/rtl/ntbp_accum.sv */
// ----------------------------------------------------------------------------
// ntbp_accum
// Decodes each accepted symbol, updates the packing and hash state and
// builds the queue entry that holds the results of that item.
// ----------------------------------------------------------------------------
module ntbp_accum (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        symbol,
    input  logic              last_base,
    output logic              push,
    output ntbp_pkg::rec_t    rec
);

    logic [7:0]          base_reg;
    logic [7:0]          base_next;
    logic [7:0]          flag_reg;
    logic [7:0]          flag_next;
    logic [2:0]          pos_reg;
    logic [2:0]          pos_next;
    logic [63:0]         hash_reg;
    logic [63:0]         hash_next;
    logic                seen_reg;
    logic                seen_next;

    ntbp_pkg::sym_code_t sc;
    logic [2:0]          shift;
    logic [7:0]          base_new;
    logic [7:0]          flag_new;
    logic [63:0]         hash_new;
    logic                seen_new;
    logic                base_full;
    logic                flag_full;

    // merge the new base into the partial bytes and the hash
    always_comb
    begin
        sc        = ntbp_pkg::classify(symbol);
        shift     = {pos_reg[1:0], 1'b0};
        base_new  = base_reg | ({6'd0, sc.code} << shift);
        flag_new  = flag_reg | ({7'd0, sc.amb} << pos_reg);
        hash_new  = {hash_reg[61:0], sc.code};
        seen_new  = seen_reg | sc.amb;
        base_full = (pos_reg[1:0] == 2'b11) || last_base;
        flag_full = (pos_reg == 3'd7) || last_base;
    end

    // queue entry for this item
    always_comb
    begin
        rec.has_base    = base_full;
        rec.has_flag    = flag_full;
        rec.has_summary = last_base;
        rec.base_byte   = base_new;
        rec.flag_byte   = flag_new;
        rec.hash        = seen_new ? 64'd0 : hash_new;
        rec.definite    = ~seen_new;
        push            = accept && (base_full || flag_full);
    end

    // next state: back to the start after the last base
    always_comb
    begin
        base_next = base_reg;
        flag_next = flag_reg;
        pos_next  = pos_reg;
        hash_next = hash_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            if (last_base)
            begin
                base_next = 8'd0;
                flag_next = 8'd0;
                pos_next  = 3'd0;
                hash_next = ntbp_pkg::HASH_SEED;
                seen_next = 1'b0;
            end
            else
            begin
                base_next = base_full ? 8'd0 : base_new;
                flag_next = flag_full ? 8'd0 : flag_new;
                pos_next  = pos_reg + 3'd1;
                hash_next = hash_new;
                seen_next = seen_new;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 8'd0;
            flag_reg <= 8'd0;
            pos_reg  <= 3'd0;
            hash_reg <= ntbp_pkg::HASH_SEED;
            seen_reg <= 1'b0;
        end
        else
        begin
            base_reg <= base_next;
            flag_reg <= flag_next;
            pos_reg  <= pos_next;
            hash_reg <= hash_next;
            seen_reg <= seen_next;
        end
    end

    // an item that ends a sequence always carries all three results
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_base) |-> (push && rec.has_base && rec.has_flag && rec.has_summary))
    else $error("last base without full result set");

    // a full flag byte always coincides with a full base byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && rec.has_flag) |-> rec.has_base)
    else $error("flag byte without base byte");

    // the position counter returns to zero and the hash to its seed after a sequence ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_base) |=> (pos_reg == 3'd0 && hash_reg == ntbp_pkg::HASH_SEED))
    else $error("state not restored after last base");

endmodule

/* hw/rtl/ntbp_result_queue.sv */
// ----------------------------------------------------------------------------
// ntbp_result_queue
// Two-entry queue of per-item result sets; walks each entry and hands its
// results out one per handshake.
// ----------------------------------------------------------------------------
module ntbp_result_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ntbp_pkg::rec_t    rec,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic [7:0]        packed_byte,
    output logic [63:0]       seq_hash,
    output logic              all_definite,
    output logic              end_of_run
);

    ntbp_pkg::rec_t      rec_reg [2];
    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic                base_done_reg;
    logic                base_done_next;
    logic                flag_done_reg;
    logic                flag_done_next;

    ntbp_pkg::rec_t      head;
    ntbp_pkg::kind_t     cur_kind;
    logic                cur_last;
    logic                take;
    logic                pop;

    assign head      = rec_reg[rd_ptr_reg];
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign take      = out_valid && !out_stall;
    assign pop       = take && cur_last;

    // pick the next pending result of the head entry
    always_comb
    begin
        priority if (head.has_base && !base_done_reg)
        begin
            cur_kind = ntbp_pkg::KIND_BASE;
            cur_last = !head.has_flag && !head.has_summary;
        end
        else if (head.has_flag && !flag_done_reg)
        begin
            cur_kind = ntbp_pkg::KIND_FLAG;
            cur_last = !head.has_summary;
        end
        else
        begin
            cur_kind = ntbp_pkg::KIND_SUMMARY;
            cur_last = 1'b1;
        end
    end

    // result fields
    always_comb
    begin
        kind         = cur_kind;
        packed_byte  = 8'd0;
        seq_hash     = 64'd0;
        all_definite = 1'b0;
        end_of_run   = cur_last;
        unique case (cur_kind)
            ntbp_pkg::KIND_BASE:
            begin
                packed_byte = head.base_byte;
            end
            ntbp_pkg::KIND_FLAG:
            begin
                packed_byte = head.flag_byte;
            end
            ntbp_pkg::KIND_SUMMARY:
            begin
                seq_hash     = head.hash;
                all_definite = head.definite;
            end
            default:
            begin
                packed_byte = 8'd0;
            end
        endcase
    end

    // progress through the head entry
    always_comb
    begin
        base_done_next = base_done_reg;
        flag_done_next = flag_done_reg;
        count_next     = count_reg + {1'b0, push} - {1'b0, pop};
        if (pop)
        begin
            base_done_next = 1'b0;
            flag_done_next = 1'b0;
        end
        else if (take)
        begin
            if (cur_kind == ntbp_pkg::KIND_BASE)
            begin
                base_done_next = 1'b1;
            end
            else
            begin
                flag_done_next = 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rec_reg[wr_ptr_reg] <= rec;
        end
    end

    // queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 2'd0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            base_done_reg <= 1'b0;
            flag_done_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            wr_ptr_reg    <= wr_ptr_reg ^ push;
            rd_ptr_reg    <= rd_ptr_reg ^ pop;
            base_done_reg <= base_done_next;
            flag_done_reg <= flag_done_next;
        end
    end

    // never written while full
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
    else $error("push into full result queue");

    // occupancy stays within two entries
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
    else $error("result queue count out of range");

    // a summary is always the closing result of its entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cur_kind == ntbp_pkg::KIND_SUMMARY) |-> end_of_run)
    else $error("summary not marked as end of run");

endmodule

/* tb/tb_nucleotide_two_bit_packer_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nucleotide_two_bit_packer_core
// Sends ascii nucleotide sequences into the packer and checks every base byte,
// flag byte and summary against a cycle-free predictor kept in this bench.
// Both channels idle in random bursts, except in the final stretch.
// ----------------------------------------------------------------------------
module tb_nucleotide_two_bit_packer_core;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;

    // letters of the four definite bases, both cases
    localparam logic [7:0] BASE_LETTERS [8] = '{
        ntbp_pkg::CHAR_A_UC, ntbp_pkg::CHAR_C_UC, ntbp_pkg::CHAR_G_UC, ntbp_pkg::CHAR_T_UC,
        ntbp_pkg::CHAR_A_LC, ntbp_pkg::CHAR_C_LC, ntbp_pkg::CHAR_G_LC, ntbp_pkg::CHAR_T_LC
    };

    // one result as the block should present it
    typedef struct {
        ntbp_pkg::kind_t kind;
        logic [7:0]      pbyte;
        logic [63:0]     hash;
        logic            definite;
        logic            eor;
    } packer_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  symbol = 8'h00;
    logic        last_base = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  packed_byte;
    logic [63:0] seq_hash;
    logic        all_definite;
    logic        end_of_run;

    // predictor state for the sequence in progress
    logic [7:0]  acc_bases = 8'h00;
    logic [7:0]  acc_flags = 8'h00;
    logic [2:0]  base_pos = 3'd0;
    logic [63:0] hash_acc = ntbp_pkg::HASH_SEED;
    logic        any_ambiguous = 1'b0;

    packer_result_t pending_results[$];
    packer_result_t got_expected;
    int  error_count = 0;
    int  cycle_count = 0;
    bit  idle_on = 1'b1;

    nucleotide_two_bit_packer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .symbol       (symbol),
        .last_base    (last_base),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .packed_byte  (packed_byte),
        .seq_hash     (seq_hash),
        .all_definite (all_definite),
        .end_of_run   (end_of_run)
    );

    // clock
    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_nucleotide_two_bit_packer_core failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    // append one expected result at the tail of the queue
    task automatic queue_expected(input packer_result_t res);
        pending_results.insert(pending_results.size(), res);
    endtask

    // expected results of one base, updating the sequence state
    task automatic pack_nucleotide(input logic [7:0] sym, input logic last);
        logic [1:0] code;
        logic       amb;
        bit         emit_base;
        bit         emit_flag;
        code = ntbp_pkg::CODE_A;
        amb  = 1'b0;
        case (sym)
            ntbp_pkg::CHAR_A_UC, ntbp_pkg::CHAR_A_LC: code = ntbp_pkg::CODE_A;
            ntbp_pkg::CHAR_C_UC, ntbp_pkg::CHAR_C_LC: code = ntbp_pkg::CODE_C;
            ntbp_pkg::CHAR_G_UC, ntbp_pkg::CHAR_G_LC: code = ntbp_pkg::CODE_G;
            ntbp_pkg::CHAR_T_UC, ntbp_pkg::CHAR_T_LC: code = ntbp_pkg::CODE_T;
            default: amb = 1'b1;
        endcase

        acc_bases     = acc_bases | ({6'b0, code} << {base_pos[1:0], 1'b0});
        acc_flags     = acc_flags | ({7'b0, amb} << base_pos);
        hash_acc      = (hash_acc << 2) + {62'b0, code};
        any_ambiguous = any_ambiguous | amb;

        emit_base = (base_pos[1:0] == 2'd3) || last;
        emit_flag = (base_pos == 3'd7) || last;

        if (emit_base)
        begin
            queue_expected('{ntbp_pkg::KIND_BASE, acc_bases, 64'd0, 1'b0, !emit_flag});
            acc_bases = 8'h00;
        end
        if (emit_flag)
        begin
            queue_expected('{ntbp_pkg::KIND_FLAG, acc_flags, 64'd0, 1'b0, !last});
            acc_flags = 8'h00;
        end
        if (last)
        begin
            queue_expected('{ntbp_pkg::KIND_SUMMARY, 8'h00,
                             any_ambiguous ? 64'd0 : hash_acc,
                             !any_ambiguous, 1'b1});
            acc_bases     = 8'h00;
            acc_flags     = 8'h00;
            base_pos      = 3'd0;
            hash_acc      = ntbp_pkg::HASH_SEED;
            any_ambiguous = 1'b0;
        end
        else
        begin
            base_pos = base_pos + 3'd1;
        end
    endtask

    // send one item, with a random gap ahead of it while idling is on
    task automatic send_base(input logic [7:0] sym, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        symbol    <= sym;
        last_base <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pack_nucleotide(sym, last);
    endtask

    task automatic send_string(input string seq);
        for (int i = 0; i < seq.len(); i++)
        begin
            send_base(seq[i], i == seq.len() - 1);
        end
    endtask

    function automatic logic [7:0] random_symbol(input bit allow_amb);
        if (allow_amb && $urandom_range(0, 3) == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        return BASE_LETTERS[$urandom_range(0, 7)];
    endfunction

    // output side: random stall bursts while idling is on
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // compare each accepted result with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, kind", 64'(kind), 64'd0);
            end
            else
            begin
                got_expected = pending_results.pop_front();
                if (kind !== got_expected.kind)
                    report_mismatch("kind", 64'(kind), 64'(got_expected.kind));
                if (packed_byte !== got_expected.pbyte)
                    report_mismatch("packed_byte", 64'(packed_byte), 64'(got_expected.pbyte));
                if (seq_hash !== got_expected.hash)
                    report_mismatch("seq_hash", seq_hash, got_expected.hash);
                if (all_definite !== got_expected.definite)
                    report_mismatch("all_definite", 64'(all_definite),
                                    64'(got_expected.definite));
                if (end_of_run !== got_expected.eor)
                    report_mismatch("end_of_run", 64'(end_of_run), 64'(got_expected.eor));
            end
        end
    end

    // every letter in both cases, filling two base bytes and a flag byte exactly
    task automatic test_definite_letters();
        send_string("ACGTacgt");
    endtask

    // one-base sequence: partial base, flag and summary together
    task automatic test_single_base();
        send_string("g");
    endtask

    // non-letter bytes, letter look-alikes and the byte extremes
    task automatic test_ambiguous_symbols();
        send_base(8'h00, 1'b0);
        send_base(8'h4E, 1'b0);
        send_base(8'hFF, 1'b0);
        send_base(8'hC1, 1'b0);
        send_base(8'h55, 1'b0);
        send_base(ntbp_pkg::CHAR_T_LC, 1'b1);
    endtask

    // sequence ending mid-byte, then a new sequence to see the state cleared
    task automatic test_partial_bytes();
        send_string("TTGCA");
        send_string("cGt");
    endtask

    // random sequences, mostly all-definite, some long enough to wrap the hash
    task automatic test_random_sequences(input int item_count);
        int  sent;
        int  len;
        bit  mixed;
        sent = 0;
        while (sent < item_count)
        begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(30, 60);
            else
                len = $urandom_range(1, 20);
            mixed = ($urandom_range(0, 9) < 4);
            for (int i = 0; i < len; i++)
            begin
                send_base(random_symbol(mixed), i == len - 1);
            end
            sent += len;
        end
    endtask

    // sender holds off until every pending result has come out
    task automatic test_drain_pause();
        send_string("GATT");
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        send_string("acA");
    endtask

    // stimulus
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_definite_letters();
        test_single_base();
        test_ambiguous_symbols();
        test_partial_bytes();
        test_random_sequences(110);
        test_drain_pause();
        test_random_sequences(80);
        idle_on = 1'b0;
        test_random_sequences(50);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            report_mismatch("results left over", 64'(pending_results.size()), 64'd0);
        end

        if (error_count == 0)
        begin
            $display("tb_nucleotide_two_bit_packer_core passed");
        end
        else
        begin
            $display("tb_nucleotide_two_bit_packer_core failed");
        end
        $finish;
    end

endmodule
